// ===== hw/rtl/xxh64_pkg.sv =====
// Package for the XXH64 stream hasher.
// Holds the field widths, the XXH64 primes and the rotate helper.
// It depends on nothing else.
package xxh64_pkg;

   localparam int WORD_W  = 64;
   localparam int COUNT_W = 4;
   localparam int HALF_W  = WORD_W / 2;

   localparam logic [WORD_W-1:0] PRIME_A = 64'h9E37_79B1_85EB_CA87;
   localparam logic [WORD_W-1:0] PRIME_B = 64'hC2B2_AE3D_27D4_EB4F;
   localparam logic [WORD_W-1:0] PRIME_C = 64'h1656_67B1_9E37_79F9;
   localparam logic [WORD_W-1:0] PRIME_D = 64'h85EB_CA77_C2B2_AE63;
   localparam logic [WORD_W-1:0] PRIME_E = 64'h27D4_EB2F_1656_67C5;

   localparam int ROT_ROUND = 31;
   localparam int ROT_TAIL  = 27;
   localparam int ROT_CHUNK = 23;
   localparam int ROT_BYTE  = 11;
   localparam int ROT_LANE0 = 1;
   localparam int ROT_LANE1 = 7;
   localparam int ROT_LANE2 = 12;
   localparam int ROT_LANE3 = 18;
   localparam int AV_SHIFT0 = 33;
   localparam int AV_SHIFT1 = 29;
   localparam int AV_SHIFT2 = 32;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
      rotl = (x << r) | (x >> (WORD_W - r));
   endfunction

endpackage

// ===== hw/rtl/xxh64_if.sv =====
// Channel interfaces of the XXH64 stream hasher: request, response and seed write.
// Each carries valid, ready and its payload; widths come from xxh64_pkg.
interface xxh64_req_if;
   logic                            valid;
   logic                            ready;
   logic [xxh64_pkg::WORD_W-1:0]    data_word;
   logic [xxh64_pkg::COUNT_W-1:0]   byte_count;
   logic                            last_word;
   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface xxh64_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [xxh64_pkg::WORD_W-1:0] hash_value;
   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

interface xxh64_csr_if;
   logic                         valid;
   logic                         ready;
   logic [xxh64_pkg::WORD_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/xxhash64_stream_hasher.sv =====
// Top level of the XXH64 stream hasher: sequencer, lane state and shared multiplier.
// Depends on xxh64_pkg and the channel interfaces in xxh64_if.sv.
//
// The block takes one word at a time and is not ready while it works on it. Every
// 64-bit multiply runs on one shared 32 by 32 multiplier as partial products of the
// operand halves, after a state that sets up its operands. A word that only fills
// the stripe buffer is stored and the block is ready again; a word that completes a
// stripe runs four lane rounds of two multiplies each. The last word adds the merge
// of the four lanes for a long message, then the length, a round per tail word, the
// 4-byte chunk, a round per single byte, the avalanche and the hand-off. The seed is
// taken at any time; a digest is held on the response channel until it is taken.
module xxhash64_stream_hasher (
   input logic           clock,
   input logic           reset,
   xxh64_req_if.sink     req_ch,
   xxh64_rsp_if.source   rsp_ch,
   xxh64_csr_if.sink     csr_ch
);

   localparam int W = xxh64_pkg::WORD_W;
   localparam int H = xxh64_pkg::HALF_W;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_FOLD_M1, S_FOLD_ADD, S_FOLD_WR, S_FIN_INIT, S_SUM,
      S_MRG_M1, S_MRG_R, S_MRG_X, S_MRG_D, S_ADD_LEN, S_TAIL_CHK, S_TW_M1, S_TW_R,
      S_TW_X, S_TW_D, S_C4_X, S_C4_D, S_B_X, S_B_D, S_AV2, S_AV3, S_DONE, S_MUL
   } state_type;

   state_type         state_ff, state_in, ret_ff, ret_in;
   logic [W-1:0]      seed_ff, seed_in;
   logic [W-1:0]      lane_ff [4];
   logic [W-1:0]      lane_in [4];
   logic [W-1:0]      buf_ff [3];
   logic [W-1:0]      buf_in [3];
   logic [1:0]        pos_ff, pos_in;
   logic [W-1:0]      len_ff, len_in;
   logic              long_ff, long_in;
   logic [W-1:0]      w_ff, w_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              last_ff, last_in;
   logic [2:0]        idx_ff, idx_in;
   logic [W-1:0]      h_ff, h_in;
   logic [W-1:0]      tw_ff, tw_in;
   logic [W-1:0]      ma_ff, ma_in, mb_ff, mb_in, mp_ff, mp_in;
   logic [1:0]        mstep_ff, mstep_in;
   logic              rv_ff, rv_in;
   logic [W-1:0]      out_ff, out_in;

   logic [3:0]        cnt_sat;
   logic [W-1:0]      w_masked;
   logic [H-1:0]      mx, my;
   logic [W-1:0]      pp;
   logic [W-1:0]      lane_sel, sum_term, fold_word;

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rv_ff;
   assign rsp_ch.hash_value = out_ff;

   always_comb begin
      cnt_sat = (req_ch.byte_count > 4'd8) ? 4'd8 : req_ch.byte_count;
      for (int i = 0; i < 8; i++) begin
         w_masked[8*i +: 8] = (4'(i) < cnt_sat) ? req_ch.data_word[8*i +: 8] : 8'h00;
      end
   end

   always_comb begin
      unique case (mstep_ff)
         2'd0:    begin mx = ma_ff[H-1:0]; my = mb_ff[H-1:0]; end
         2'd1:    begin mx = ma_ff[W-1:H]; my = mb_ff[H-1:0]; end
         default: begin mx = ma_ff[H-1:0]; my = mb_ff[W-1:H]; end
      endcase
      pp = W'(mx) * W'(my);
   end

   assign lane_sel  = lane_ff[idx_ff[1:0]];
   assign fold_word = (idx_ff[1:0] == 2'd3) ? w_ff : buf_ff[idx_ff[1:0]];

   always_comb begin
      unique case (idx_ff[1:0])
         2'd0:    sum_term = xxh64_pkg::rotl(lane_sel, xxh64_pkg::ROT_LANE0);
         2'd1:    sum_term = xxh64_pkg::rotl(lane_sel, xxh64_pkg::ROT_LANE1);
         2'd2:    sum_term = xxh64_pkg::rotl(lane_sel, xxh64_pkg::ROT_LANE2);
         default: sum_term = xxh64_pkg::rotl(lane_sel, xxh64_pkg::ROT_LANE3);
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      seed_in  = seed_ff;
      lane_in  = lane_ff;
      buf_in   = buf_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      long_in  = long_ff;
      w_in     = w_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      h_in     = h_ff;
      tw_in    = tw_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      mp_in    = mp_ff;
      mstep_in = mstep_ff;
      rv_in    = rv_ff;
      out_in   = out_ff;

      if (csr_ch.valid) begin
         seed_in = csr_ch.data;
      end
      if (rv_ff && rsp_ch.ready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               last_in = req_ch.last_word;
               w_in    = req_ch.last_word ? w_masked : req_ch.data_word;
               cnt_in  = req_ch.last_word ? cnt_sat : 4'd8;
               if (len_ff == '0) begin
                  lane_in[0] = seed_ff + xxh64_pkg::PRIME_A + xxh64_pkg::PRIME_B;
                  lane_in[1] = seed_ff + xxh64_pkg::PRIME_B;
                  lane_in[2] = seed_ff;
                  lane_in[3] = seed_ff - xxh64_pkg::PRIME_A;
                  pos_in     = 2'd0;
                  long_in    = 1'b0;
               end
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            idx_in = 3'd0;
            if (cnt_ff == 4'd8 && pos_ff == 2'd3) begin
               len_in   = len_ff + W'(8);
               cnt_in   = 4'd0;
               state_in = S_FOLD_M1;
            end else if (!last_ff) begin
               buf_in[pos_ff] = w_ff;
               pos_in   = pos_ff + 2'd1;
               len_in   = len_ff + W'(8);
               state_in = S_IDLE;
            end else begin
               len_in   = len_ff + W'(cnt_ff);
               state_in = S_FIN_INIT;
            end
         end
         S_FOLD_M1: begin
            ma_in = fold_word; mb_in = xxh64_pkg::PRIME_B;
            ret_in = S_FOLD_ADD; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_FOLD_ADD: begin
            ma_in = xxh64_pkg::rotl(lane_sel + mp_ff, xxh64_pkg::ROT_ROUND);
            mb_in = xxh64_pkg::PRIME_A;
            ret_in = S_FOLD_WR; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_FOLD_WR: begin
            lane_in[idx_ff[1:0]] = mp_ff;
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd3) begin
               long_in  = 1'b1;
               pos_in   = 2'd0;
               state_in = last_ff ? S_FIN_INIT : S_IDLE;
            end else begin
               state_in = S_FOLD_M1;
            end
         end
         S_FIN_INIT: begin
            idx_in = 3'd0;
            if (long_ff) begin
               h_in     = '0;
               state_in = S_SUM;
            end else begin
               h_in     = seed_ff + xxh64_pkg::PRIME_E;
               state_in = S_ADD_LEN;
            end
         end
         S_SUM: begin
            h_in   = h_ff + sum_term;
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd3) begin
               idx_in   = 3'd0;
               state_in = S_MRG_M1;
            end
         end
         S_MRG_M1: begin
            ma_in = lane_sel; mb_in = xxh64_pkg::PRIME_B;
            ret_in = S_MRG_R; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_MRG_R: begin
            ma_in = xxh64_pkg::rotl(mp_ff, xxh64_pkg::ROT_ROUND); mb_in = xxh64_pkg::PRIME_A;
            ret_in = S_MRG_X; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_MRG_X: begin
            ma_in = h_ff ^ mp_ff; mb_in = xxh64_pkg::PRIME_A;
            ret_in = S_MRG_D; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_MRG_D: begin
            h_in   = mp_ff + xxh64_pkg::PRIME_D;
            idx_in = idx_ff + 3'd1;
            state_in = (idx_ff == 3'd3) ? S_ADD_LEN : S_MRG_M1;
         end
         S_ADD_LEN: begin
            h_in     = h_ff + len_ff;
            idx_in   = 3'd0;
            state_in = S_TAIL_CHK;
         end
         S_TAIL_CHK: begin
            mstep_in = 2'd0;
            if (idx_ff < {1'b0, pos_ff}) begin
               tw_in    = buf_ff[idx_ff[1:0]];
               state_in = S_TW_M1;
            end else if (cnt_ff == 4'd8) begin
               tw_in    = w_ff;
               cnt_in   = 4'd0;
               state_in = S_TW_M1;
            end else if (cnt_ff >= 4'd4) begin
               ma_in = W'(w_ff[H-1:0]); mb_in = xxh64_pkg::PRIME_A;
               ret_in = S_C4_X; state_in = S_MUL;
            end else if (cnt_ff != 4'd0) begin
               ma_in = W'(w_ff[7:0]); mb_in = xxh64_pkg::PRIME_E;
               ret_in = S_B_X; state_in = S_MUL;
            end else begin
               ma_in = h_ff ^ (h_ff >> xxh64_pkg::AV_SHIFT0); mb_in = xxh64_pkg::PRIME_B;
               ret_in = S_AV2; state_in = S_MUL;
            end
         end
         S_TW_M1: begin
            ma_in = tw_ff; mb_in = xxh64_pkg::PRIME_B;
            ret_in = S_TW_R; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_TW_R: begin
            ma_in = xxh64_pkg::rotl(mp_ff, xxh64_pkg::ROT_ROUND); mb_in = xxh64_pkg::PRIME_A;
            ret_in = S_TW_X; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_TW_X: begin
            ma_in = xxh64_pkg::rotl(h_ff ^ mp_ff, xxh64_pkg::ROT_TAIL);
            mb_in = xxh64_pkg::PRIME_A;
            ret_in = S_TW_D; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_TW_D: begin
            h_in     = mp_ff + xxh64_pkg::PRIME_D;
            idx_in   = idx_ff + 3'd1;
            state_in = S_TAIL_CHK;
         end
         S_C4_X: begin
            ma_in = xxh64_pkg::rotl(h_ff ^ mp_ff, xxh64_pkg::ROT_CHUNK);
            mb_in = xxh64_pkg::PRIME_B;
            ret_in = S_C4_D; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_C4_D: begin
            h_in     = mp_ff + xxh64_pkg::PRIME_C;
            w_in     = w_ff >> H;
            cnt_in   = cnt_ff - 4'd4;
            state_in = S_TAIL_CHK;
         end
         S_B_X: begin
            ma_in = xxh64_pkg::rotl(h_ff ^ mp_ff, xxh64_pkg::ROT_BYTE);
            mb_in = xxh64_pkg::PRIME_A;
            ret_in = S_B_D; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_B_D: begin
            h_in     = mp_ff;
            w_in     = w_ff >> 8;
            cnt_in   = cnt_ff - 4'd1;
            state_in = S_TAIL_CHK;
         end
         S_AV2: begin
            ma_in = mp_ff ^ (mp_ff >> xxh64_pkg::AV_SHIFT1); mb_in = xxh64_pkg::PRIME_C;
            ret_in = S_AV3; mstep_in = 2'd0; state_in = S_MUL;
         end
         S_AV3: begin
            h_in     = mp_ff ^ (mp_ff >> xxh64_pkg::AV_SHIFT2);
            pos_in   = 2'd0;
            len_in   = '0;
            long_in  = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff || rsp_ch.ready) begin
               rv_in    = 1'b1;
               out_in   = h_ff;
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            if (mstep_ff == 2'd0) begin
               mp_in = pp;
            end else begin
               mp_in = mp_ff + {pp[H-1:0], {H{1'b0}}};
            end
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd2) begin
               state_in = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      lane_ff  <= lane_in;
      buf_ff   <= buf_in;
      w_ff     <= w_in;
      cnt_ff   <= cnt_in;
      last_ff  <= last_in;
      idx_ff   <= idx_in;
      h_ff     <= h_in;
      tw_ff    <= tw_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      mp_ff    <= mp_in;
      out_ff   <= out_in;
      if (reset) begin
         state_ff <= S_IDLE;
         seed_ff  <= '0;
         pos_ff   <= 2'd0;
         len_ff   <= '0;
         long_ff  <= 1'b0;
         mstep_ff <= 2'd0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_ff  <= seed_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         long_ff  <= long_in;
         mstep_ff <= mstep_in;
         rv_ff    <= rv_in;
      end
   end

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("hasher still ready the cycle after taking a word");
   a_mul_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> mstep_ff != 2'd3)
      else $error("multiplier step beyond the last partial product");
   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> len_ff == '0 && pos_ff == 2'd0 && !long_ff)
      else $error("message state not cleared when the digest is issued");
`endif

endmodule
